[hdl/bsr_pkg.sv]
// Shared constants and state type for the byte stream reassembler.
package bsr_pkg;

  // Default store depth and stream position width
  localparam int BSR_CAPACITY   = 64;
  localparam int BSR_INDEX_BITS = 32;

  // Fixed field widths
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 7;

  // Window register value after reset
  localparam logic [CNT_W-1:0] WIN_RESET = 7'd64;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_END,
    ST_LIM,
    ST_OFF,
    ST_SCAN,
    ST_FIN,
    ST_RD,
    ST_LD,
    ST_ONE
  } bsr_state_e;

endpackage

[hdl/bsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/byte_stream_reassembler_unit.sv]
// Byte stream reassembler: windowed ring store with an in-order release walk.
// Each input passes the end, limit, offset, scan and finish states, then gives one empty result
//   or one result per released byte; results wait while the receiver stalls. A new input is taken
//   only in idle. Each released byte takes a mark scan step, a byte RAM read and a result load.
// After close, an input yields a single result. One shared subtractor against next_index does all
//   window and end tests. Reset (rst_ni low, async) clears marks, counters, state; RAM is not reset.
module byte_stream_reassembler_unit import bsr_pkg::*; #(
  parameter int CAPACITY   = BSR_CAPACITY,
  parameter int INDEX_BITS = BSR_INDEX_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [INDEX_BITS-1:0] stream_index_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  has_byte_i,
  input  logic                  end_of_stream_i,
  // result channel
  output logic                  res_valid_o,
  input  logic                  res_stall_i,
  output logic [BYTE_W-1:0]     out_byte_o,
  output logic                  out_valid_o,
  output logic                  run_last_o,
  output logic                  dropped_o,
  output logic                  stream_closed_o,
  output logic [CNT_W-1:0]      held_count_o
);

  localparam int PTR_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [PTR_W:0]   CAP_P   = (PTR_W+1)'(CAPACITY);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(CAPACITY - 1);

  // ring pointer step with wrap at CAPACITY
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == LAST_P) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  bsr_state_e state_q, state_d;

  // stream state
  logic [CNT_W-1:0]      window_q;
  logic [CAPACITY-1:0]   marks_q;
  logic [INDEX_BITS-1:0] next_index_q;
  logic                  end_known_q;
  logic [INDEX_BITS:0]   end_index_q;
  logic                  closed_flag_q;
  logic [CNT_W-1:0]      held_total_q;
  logic [PTR_W-1:0]      head_q;

  // captured input and working registers
  logic [INDEX_BITS-1:0] idx_q;
  logic [BYTE_W-1:0]     byte_q;
  logic                  has_q;
  logic                  eos_q;
  logic                  dropped_q;
  logic [CNT_W-1:0]      lim_q;
  logic [PTR_W-1:0]      scan_ptr_q;
  logic [CNT_W-1:0]      scan_cnt_q;

  // result register
  logic                  res_valid_q;
  logic [BYTE_W-1:0]     out_byte_q;
  logic                  out_valid_q;
  logic                  run_last_q;
  logic                  res_dropped_q;
  logic                  res_closed_q;
  logic [CNT_W-1:0]      res_held_q;

  // control from the output decode
  logic in_take;
  logic res_free;
  logic ram_we;
  logic ram_re;
  logic load_one;
  logic load_byte;

  logic [BYTE_W-1:0] ram_rdata;

  // shared subtractor: operand minus next_index plus carry-in, modulo the position width
  logic [INDEX_BITS-1:0] sub_a;
  logic                  sub_cin;
  logic [INDEX_BITS-1:0] diff;

  always_comb begin
    unique case (state_q)
      ST_END: begin
        sub_a   = idx_q;
        sub_cin = has_q;
      end
      ST_LIM, ST_FIN: begin
        sub_a   = end_index_q[INDEX_BITS-1:0];
        sub_cin = 1'b0;
      end
      default: begin
        sub_a   = idx_q;
        sub_cin = 1'b0;
      end
    endcase
  end

  assign diff = sub_a - next_index_q + {{(INDEX_BITS-1){1'b0}}, sub_cin};

  // effective window, capped at the store depth
  logic [CNT_W-1:0] win_eff;
  assign win_eff = (window_q > CAP_CNT) ? CAP_CNT : window_q;

  // insert slot = head + offset, wrapped
  logic [PTR_W:0]   slot_sum;
  logic [PTR_W-1:0] ins_slot;
  assign slot_sum = {1'b0, head_q} + {1'b0, diff[PTR_W-1:0]};
  assign ins_slot = (slot_sum >= CAP_P) ? PTR_W'(slot_sum - CAP_P) : slot_sum[PTR_W-1:0];

  // decisions of the individual steps
  logic end_ok;
  logic lim_short;
  logic off_in;
  logic scan_hit;
  logic fin_closed;
  assign end_ok     = (diff <= {{(INDEX_BITS-CNT_W){1'b0}}, win_eff});
  assign lim_short  = end_known_q && (diff < {{(INDEX_BITS-CNT_W){1'b0}}, win_eff});
  assign off_in     = (diff < {{(INDEX_BITS-CNT_W){1'b0}}, lim_q});
  assign scan_hit   = marks_q[scan_ptr_q] && (scan_cnt_q != CAP_CNT);
  assign fin_closed = end_known_q && (diff == {{(INDEX_BITS-CNT_W){1'b0}}, scan_cnt_q});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = closed_flag_q ? ST_ONE : ST_END;
        end
      end
      ST_END:  state_d = ST_LIM;
      ST_LIM:  state_d = ST_OFF;
      ST_OFF:  state_d = ST_SCAN;
      ST_SCAN: begin
        if (!scan_hit) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = (scan_cnt_q == '0) ? ST_ONE : ST_RD;
      ST_RD: begin
        if (res_free) begin
          state_d = ST_LD;
        end
      end
      ST_LD:   state_d = (scan_cnt_q == CNT_W'(1)) ? ST_IDLE : ST_RD;
      ST_ONE: begin
        if (res_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output decode
  assign res_free = !res_valid_q || !res_stall_i;

  always_comb begin
    in_stall_o = 1'b1;
    in_take    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    load_one   = 1'b0;
    load_byte  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        in_take    = in_valid_i;
      end
      ST_OFF:  ram_we    = has_q && off_in && !marks_q[ins_slot];
      ST_RD:   ram_re    = res_free;
      ST_LD:   load_byte = 1'b1;
      ST_ONE:  load_one  = res_free;
      default: begin
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_RESET;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  // stream state updates, one step per state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q       <= '0;
      next_index_q  <= '0;
      end_known_q   <= 1'b0;
      end_index_q   <= '0;
      closed_flag_q <= 1'b0;
      held_total_q  <= '0;
      head_q        <= '0;
      dropped_q     <= 1'b0;
      scan_ptr_q    <= '0;
      scan_cnt_q    <= '0;
      lim_q         <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            dropped_q <= closed_flag_q && has_byte_i;
          end
        end
        ST_END: begin
          if (eos_q && end_ok) begin
            end_known_q <= 1'b1;
            end_index_q <= {1'b0, idx_q} + {{INDEX_BITS{1'b0}}, has_q};
          end
        end
        ST_LIM: begin
          lim_q <= lim_short ? diff[CNT_W-1:0] : win_eff;
        end
        ST_OFF: begin
          if (has_q) begin
            if (!off_in || marks_q[ins_slot]) begin
              dropped_q <= 1'b1;
            end else begin
              marks_q[ins_slot] <= 1'b1;
              held_total_q      <= held_total_q + 1'b1;
            end
          end
          scan_ptr_q <= head_q;
          scan_cnt_q <= '0;
        end
        ST_SCAN: begin
          if (scan_hit) begin
            scan_ptr_q <= ptr_inc(scan_ptr_q);
            scan_cnt_q <= scan_cnt_q + 1'b1;
          end
        end
        ST_FIN: begin
          // commit the state seen after the whole run
          next_index_q <= next_index_q + {{(INDEX_BITS-CNT_W){1'b0}}, scan_cnt_q};
          if (fin_closed) begin
            closed_flag_q <= 1'b1;
            marks_q       <= '0;
            held_total_q  <= '0;
          end else begin
            held_total_q  <= held_total_q - scan_cnt_q;
          end
        end
        ST_LD: begin
          marks_q[head_q] <= 1'b0;
          head_q          <= ptr_inc(head_q);
          scan_cnt_q      <= scan_cnt_q - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      idx_q  <= stream_index_i;
      byte_q <= data_byte_i;
      has_q  <= has_byte_i;
      eos_q  <= end_of_stream_i;
    end
  end

  // byte store
  bsr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ins_slot),
    .wdata_i (byte_q),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_one || load_byte) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_one || load_byte) begin
      out_byte_q    <= load_byte ? ram_rdata : '0;
      out_valid_q   <= load_byte;
      run_last_q    <= load_one || (scan_cnt_q == CNT_W'(1));
      res_dropped_q <= dropped_q;
      res_closed_q  <= closed_flag_q;
      res_held_q    <= held_total_q;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_valid_o     = out_valid_q;
  assign run_last_o      = run_last_q;
  assign dropped_o       = res_dropped_q;
  assign stream_closed_o = res_closed_q;
  assign held_count_o    = res_held_q;

  // checks
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_total_q <= CAP_CNT)
    else $error("held count above store depth");

  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_flag_q |=> closed_flag_q)
    else $error("stream reopened after close");

  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LD) |-> ($past(state_q) == ST_RD))
    else $error("byte load without a preceding store read");

  a_load_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LD) |-> (!res_valid_q || !res_stall_i))
    else $error("byte load into a stalled result register");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_valid_q) |-> (out_byte_q == '0 && run_last_q))
    else $error("empty result carries a byte or is not last");

endmodule

[tb/byte_stream_reassembler_unit_tb.sv]
// Self-checking testbench for the byte stream reassembler: random out-of-order streams.
module byte_stream_reassembler_unit_tb import bsr_pkg::*; ();

  localparam int CAP      = BSR_CAPACITY;
  localparam int IW       = BSR_INDEX_BITS;
  localparam int HOLD_CYC = 300;

  // One input transfer
  typedef struct packed {
    logic [IW-1:0]     idx;
    logic [BYTE_W-1:0] data;
    logic              has;
    logic              eos;
  } seg_t;

  // Reassembly state as the block keeps it
  typedef struct packed {
    logic [CAP-1:0][BYTE_W-1:0] store;
    logic [CAP-1:0]             marks;
    logic [IW-1:0]              next;
    logic                       end_known;
    logic [IW:0]                end_idx;
    logic                       closed;
    logic [CNT_W-1:0]           held;
    logic [31:0]                head;
    logic [CNT_W-1:0]           window;
  } reasm_t;

  // What one input releases
  typedef struct packed {
    logic [7:0]                 n;
    logic [CAP-1:0][BYTE_W-1:0] run;
    logic                       dropped;
    logic                       closed;
    logic [CNT_W-1:0]           held;
  } drain_t;

  // One result transfer
  typedef struct packed {
    logic [BYTE_W-1:0] byte_v;
    logic              valid;
    logic              last;
    logic              dropped;
    logic              closed;
    logic [CNT_W-1:0]  held;
  } res_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata_i     = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic [IW-1:0]         stream_index_i  = '0;
  logic [BYTE_W-1:0]     data_byte_i     = '0;
  logic                  has_byte_i      = 1'b0;
  logic                  end_of_stream_i = 1'b0;
  logic                  res_valid_o;
  logic                  res_stall_i     = 1'b0;
  logic [BYTE_W-1:0]     out_byte_o;
  logic                  out_valid_o;
  logic                  run_last_o;
  logic                  dropped_o;
  logic                  stream_closed_o;
  logic [CNT_W-1:0]      held_count_o;

  byte_stream_reassembler_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .stream_index_i  (stream_index_i),
    .data_byte_i     (data_byte_i),
    .has_byte_i      (has_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .res_valid_o     (res_valid_o),
    .res_stall_i     (res_stall_i),
    .out_byte_o      (out_byte_o),
    .out_valid_o     (out_valid_o),
    .run_last_o      (run_last_o),
    .dropped_o       (dropped_o),
    .stream_closed_o (stream_closed_o),
    .held_count_o    (held_count_o)
  );

  seg_t   segment_q[$];   // transfers waiting for the driver
  res_t   release_q[$];   // results still owed by the block
  reasm_t chk_st;         // state advanced on accepted transfers
  reasm_t plan_st;        // state advanced as stimulus is generated
  seg_t   cur_seg;
  drain_t acc_drain;
  int     gap_cnt    = 0;
  int     stall_left = 0;
  int     hold_left  = 0;
  int     hold_seq   = 0;
  int     hold_seen  = 0;
  int     err_cnt    = 0;
  int     res_cnt    = 0;
  int     gen_cnt    = 0;
  logic   no_idle      = 1'b0;
  logic   sender_pause = 1'b0;
  logic   close_ok     = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Effective window: register value capped at the store depth
  function automatic logic [IW-1:0] eff_win(input reasm_t st);
    return (st.window > CAP) ? IW'(CAP) : IW'(st.window);
  endfunction

  // Gap or stall length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Apply one transfer to a reassembly state and collect what it releases
  task automatic reassemble(inout reasm_t st, input seg_t sg, output drain_t d);
    logic [IW-1:0] wlim, rel, off, lim;
    int            slot;
    d    = '0;
    wlim = eff_win(st);
    if (!st.closed) begin
      // end marker: taken when it lies within the window
      if (sg.eos) begin
        rel = sg.idx + IW'(sg.has) - st.next;
        if (rel <= wlim) begin
          st.end_known = 1'b1;
          st.end_idx   = {1'b0, sg.idx} + (IW+1)'(sg.has);
        end
      end
      // store the byte unless stale, out of window, past end or already held
      if (sg.has) begin
        off = sg.idx - st.next;
        lim = wlim;
        if (st.end_known) begin
          rel = st.end_idx[IW-1:0] - st.next;
          if (rel < lim) lim = rel;
        end
        if (off >= lim) begin
          d.dropped = 1'b1;
        end else begin
          slot = (int'(st.head) + int'(off)) % CAP;
          if (st.marks[slot]) begin
            d.dropped = 1'b1;
          end else begin
            st.store[slot] = sg.data;
            st.marks[slot] = 1'b1;
            st.held        = st.held + CNT_W'(1);
          end
        end
      end
      // release the contiguous run at the head
      while (d.n < CAP && st.marks[st.head]) begin
        d.run[d.n]        = st.store[st.head];
        st.marks[st.head] = 1'b0;
        if (st.held > 0) st.held = st.held - CNT_W'(1);
        st.head = (st.head + 32'd1) % 32'(CAP);
        st.next = st.next + IW'(1);
        d.n     = d.n + 8'd1;
      end
      if (st.end_known && st.end_idx[IW-1:0] == st.next) begin
        st.closed = 1'b1;
        st.marks  = '0;
        st.held   = '0;
      end
    end else if (sg.has) begin
      d.dropped = 1'b1;
    end
    d.closed = st.closed;
    d.held   = st.held;
  endtask

  task automatic report_mismatch(input string what, input res_t got, input res_t want);
    err_cnt++;
    if (err_cnt <= 40)
      $display({"mismatch %s at result %0d: got %02h/%0b/%0b/%0b/%0b/%0d",
                " want %02h/%0b/%0b/%0b/%0b/%0d"},
               what, res_cnt, got.byte_v, got.valid, got.last, got.dropped, got.closed,
               got.held, want.byte_v, want.valid, want.last, want.dropped, want.closed,
               want.held);
  endtask

  // Queue one transfer; unless closing is allowed, swap out anything that would close
  task automatic add_item(input logic [IW-1:0] idx, input logic [BYTE_W-1:0] data,
                          input logic has, input logic eos);
    seg_t   sg;
    reasm_t tmp;
    drain_t d;
    sg = {idx, data, has, eos};
    if (!close_ok) begin
      tmp = plan_st;
      reassemble(tmp, sg, d);
      if (tmp.closed) begin
        // push the end out to the window edge instead
        sg  = {plan_st.next + eff_win(plan_st), 8'($urandom), 1'b0, 1'b1};
        tmp = plan_st;
        reassemble(tmp, sg, d);
        if (tmp.closed) sg = {IW'($urandom), 8'($urandom), 1'b0, 1'b0};
      end
    end
    reassemble(plan_st, sg, d);
    segment_q.push_back(sg);
    gen_cnt++;
  endtask

  // A well-formed stretch of k bytes from the next position, shuffled or reversed
  task automatic seq_block(input int k, input logic rev, input logic close_last);
    int            ord[CAP];
    int            i, j, t;
    logic [IW-1:0] base;
    logic          e;
    base = plan_st.next;
    for (i = 0; i < k; i++) ord[i] = rev ? k - 1 - i : i;
    if (!rev) begin
      for (i = k - 1; i > 0; i--) begin
        j      = $urandom_range(0, i);
        t      = ord[i];
        ord[i] = ord[j];
        ord[j] = t;
      end
    end
    for (i = 0; i < k; i++) begin
      if (close_last) e = (ord[i] == k - 1);
      else e = (eff_win(plan_st) >= 4) && ($urandom_range(0, 99) < 3);
      add_item(base + IW'(ord[i]), 8'($urandom), 1'b1, e);
      // occasional overlapping copy with fresh random content
      if ($urandom_range(0, 99) < 8)
        add_item(base + IW'(ord[i]), 8'($urandom), 1'b1, 1'b0);
    end
  endtask

  // Stale, far-out or fully random transfer
  task automatic noise_item();
    logic [IW-1:0] idx;
    int            r;
    r = $urandom_range(0, 99);
    if (r < 40) idx = IW'($urandom);
    else if (r < 70) idx = plan_st.next - IW'($urandom_range(1, 300));
    else idx = plan_st.next + eff_win(plan_st) + IW'($urandom_range(0, 100));
    add_item(idx, 8'($urandom), 1'($urandom), ($urandom_range(0, 9) == 0));
  endtask

  task automatic random_phase(input int count);
    int start, w, k;
    start = gen_cnt;
    while (gen_cnt - start < count) begin
      w = int'(eff_win(plan_st));
      if (w == 0 || $urandom_range(0, 99) < 25) begin
        noise_item();
      end else if ($urandom_range(0, 99) < 10) begin
        seq_block(w, 1'b1, 1'b0);
      end else begin
        k = $urandom_range(1, (w < 16) ? w : 16);
        seq_block(k, 1'b0, 1'b0);
      end
    end
    // keep a pending end from pinning the stream before the window shrinks
    if (plan_st.end_known && !plan_st.closed && eff_win(plan_st) > 0)
      add_item(plan_st.next + eff_win(plan_st), 8'h00, 1'b0, 1'b1);
  endtask

  task automatic wait_idle();
    while (segment_q.size() != 0 || in_valid_i || release_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [CNT_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i       <= 1'b1;
    cfg_wdata_i    <= v;
    chk_st.window  = v;
    plan_st.window = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Driver: offers queued transfers, predicts on every accepted one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        reassemble(chk_st, cur_seg, acc_drain);
        if (acc_drain.n == 0) begin
          release_q.push_back({8'h00, 1'b0, 1'b1, acc_drain.dropped, acc_drain.closed,
                               acc_drain.held});
        end else begin
          for (int k = 0; k < int'(acc_drain.n); k++)
            release_q.push_back({acc_drain.run[k], 1'b1, (k == int'(acc_drain.n) - 1),
                                 acc_drain.dropped, acc_drain.closed, acc_drain.held});
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid_i <= 1'b0;
        end else if (segment_q.size() != 0 && !sender_pause) begin
          cur_seg         = segment_q.pop_front();
          stream_index_i  <= cur_seg.idx;
          data_byte_i     <= cur_seg.data;
          has_byte_i      <= cur_seg.has;
          end_of_stream_i <= cur_seg.eos;
          in_valid_i      <= 1'b1;
          gap_cnt = (!no_idle && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random runs, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_stall_i <= 1'b1;
    end else if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYC - 1;
      res_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall_i <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      stall_left = gap_len() - 1;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= 1'b0;
    end
  end

  // Monitor: each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      got = {out_byte_o, out_valid_o, run_last_o, dropped_o, stream_closed_o, held_count_o};
      if (release_q.size() == 0) begin
        report_mismatch("unexpected result", got, '0);
      end else begin
        want = release_q.pop_front();
        if (got !== want) report_mismatch("field", got, want);
      end
      res_cnt++;
    end
  end

  // Stimulus sequence and verdict
  initial begin
    chk_st        = '0;
    chk_st.window = WIN_RESET;
    plan_st       = chk_st;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: single release, short run, duplicate, stale, window edges, end markers
    add_item(plan_st.next,          8'h00, 1'b1, 1'b0);
    add_item(plan_st.next + 2,      8'hFF, 1'b1, 1'b0);
    add_item(plan_st.next + 1,      8'h5A, 1'b1, 1'b0);
    add_item(plan_st.next,          8'h11, 1'b1, 1'b0);
    add_item(plan_st.next + 3,      8'hA5, 1'b1, 1'b0);
    add_item(plan_st.next + 3,      8'h3C, 1'b1, 1'b0);
    add_item(plan_st.next - 1,      8'h77, 1'b1, 1'b0);
    add_item(plan_st.next + 64,     8'h42, 1'b1, 1'b0);
    add_item(plan_st.next + 63,     8'h24, 1'b1, 1'b0);
    add_item(32'hFFFF_FFFF,         8'h81, 1'b1, 1'b0);
    add_item(plan_st.next + 5,      8'hC3, 1'b0, 1'b0);
    add_item(plan_st.next + 65,     8'h00, 1'b0, 1'b1);
    add_item(plan_st.next + 10,     8'h99, 1'b1, 1'b1);
    add_item(plan_st.next + 11,     8'h66, 1'b1, 1'b0);
    add_item(plan_st.next + 64,     8'h00, 1'b0, 1'b1);
    add_item(plan_st.next + 2,      8'h12, 1'b1, 1'b0);
    add_item(plan_st.next + 1,      8'h34, 1'b1, 1'b0);
    add_item(plan_st.next,          8'h56, 1'b1, 1'b0);
    add_item(plan_st.next,          8'hE7, 1'b0, 1'b0);
    add_item(plan_st.next ^ 32'h8000_0000, 8'h18, 1'b1, 1'b0);
    random_phase(40);
    wait_idle();

    // oversized register value, with a long receiver hold-off
    write_window(7'd127);
    random_phase(45);
    hold_seq++;
    wait_idle();

    write_window(7'd1);
    random_phase(30);
    wait_idle();

    write_window(7'd0);
    random_phase(15);
    wait_idle();

    // mid-range window, back to back on both sides
    write_window(7'($urandom_range(2, 63)));
    no_idle = 1'b1;
    random_phase(40);
    wait_idle();
    no_idle = 1'b0;

    // full window, sender pauses until every result is out
    write_window(7'd64);
    random_phase(40);
    while (segment_q.size() > 30) @(negedge clk_i);
    sender_pause = 1'b1;
    while (in_valid_i || release_q.size() != 0) @(negedge clk_i);
    sender_pause = 1'b0;
    wait_idle();

    // close the stream, then transfers that must all be ignored
    close_ok = 1'b1;
    seq_block($urandom_range(4, 20), 1'b0, 1'b1);
    add_item(plan_st.next,   8'($urandom), 1'b1, 1'b0);
    add_item(IW'($urandom),  8'($urandom), 1'b0, 1'b0);
    add_item(IW'($urandom),  8'($urandom), 1'b1, 1'b1);
    add_item(plan_st.next,   8'($urandom), 1'b0, 1'b1);
    wait_idle();

    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && release_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
